### rtl/mmcs_pkg.sv
// shared types and constants for the min/max contrast stretch block
package mmcs_pkg;

   localparam int unsigned PIX_W    = 8;
   localparam int unsigned NUM_CHAN = 3;

   localparam logic [PIX_W-1:0] LEVEL_TOP    = 8'd255;
   localparam logic [PIX_W-1:0] LEVEL_BOTTOM = 8'd0;

   // request kinds carried on req_type
   typedef enum logic {
      REQ_SCAN  = 1'b0,
      REQ_APPLY = 1'b1
   } req_kind_type;

   typedef logic [PIX_W-1:0] level_type;

   // one queued apply request with the range snapshot it must use
   typedef struct packed {
      logic                          color;
      level_type [NUM_CHAN-1:0]      chan;
      level_type                     lo;
      level_type                     hi;
   } apply_entry_type;

   typedef struct packed {
      logic            push;
      apply_entry_type entry;
   } push_type;

   typedef struct packed {
      logic            valid;
      apply_entry_type entry;
   } head_type;

endpackage

### rtl/mmcs_front.sv
// front end: accepts requests, tracks the frame range, queues apply requests
module mmcs_front import mmcs_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      color_mode,
   input  logic      req_valid,
   output logic      req_stall,
   input  logic      req_type,
   input  logic      req_frame_start,
   input  level_type req_chan0,
   input  level_type req_chan1,
   input  level_type req_chan2,
   input  logic      queue_full,
   output push_type  push_o
);

   level_type min_ff, min_in;
   level_type max_ff, max_in;
   logic      accept;
   logic      is_apply;
   level_type lo_base, hi_base;
   level_type lo_a, hi_a, lo_b, hi_b, lo_c, hi_c;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign is_apply  = (req_type == REQ_APPLY);

   always_comb begin
      lo_base = req_frame_start ? LEVEL_TOP : min_ff;
      hi_base = req_frame_start ? LEVEL_BOTTOM : max_ff;
      lo_a = (req_chan0 < lo_base) ? req_chan0 : lo_base;
      hi_a = (req_chan0 > hi_base) ? req_chan0 : hi_base;
      lo_b = (req_chan1 < lo_a) ? req_chan1 : lo_a;
      hi_b = (req_chan1 > hi_a) ? req_chan1 : hi_a;
      lo_c = (req_chan2 < lo_b) ? req_chan2 : lo_b;
      hi_c = (req_chan2 > hi_b) ? req_chan2 : hi_b;
      min_in = min_ff;
      max_in = max_ff;
      if (accept && !is_apply) begin
         min_in = color_mode ? lo_c : lo_a;
         max_in = color_mode ? hi_c : hi_a;
      end
   end

   always_comb begin
      push_o.push          = accept && is_apply;
      push_o.entry.color   = color_mode;
      push_o.entry.chan[0] = req_chan0;
      push_o.entry.chan[1] = req_chan1;
      push_o.entry.chan[2] = req_chan2;
      push_o.entry.lo      = min_ff;
      push_o.entry.hi      = max_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= LEVEL_TOP;
         max_ff <= LEVEL_BOTTOM;
      end else begin
         min_ff <= min_in;
         max_ff <= max_in;
      end
   end

   // a scan always folds at least one level, so the range is ordered after it
   assert property (@(posedge clock) disable iff (reset)
      (accept && !is_apply) |=> (min_ff <= max_ff))
      else $error("range out of order after scan");

endmodule

### rtl/mmcs_queue.sv
// small register queue of apply requests between front and back
module mmcs_queue import mmcs_pkg::*; #(
   parameter int unsigned DEPTH = 4
) (
   input  logic     clock,
   input  logic     reset,
   input  push_type push_i,
   input  logic     pop_i,
   output logic     full_o,
   output head_type head_o
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   apply_entry_type [DEPTH-1:0] entry_ff;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(DEPTH - 1)) next_ptr = '0;
      else                        next_ptr = p + 1'b1;
   endfunction

   assign full_o       = (count_ff == CNT_W'(DEPTH));
   assign head_o.valid = (count_ff != '0);
   assign head_o.entry = entry_ff[head_ff];

   always_comb begin
      head_in  = pop_i ? next_ptr(head_ff) : head_ff;
      tail_in  = push_i.push ? next_ptr(tail_ff) : tail_ff;
      count_in = count_ff;
      if (push_i.push && !pop_i) count_in = count_ff + 1'b1;
      if (!push_i.push && pop_i) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push_i.push) begin
         entry_ff[tail_ff] <= push_i.entry;
      end
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) push_i.push |-> !full_o)
      else $error("push into full queue");

   assert property (@(posedge clock) disable iff (reset) pop_i |-> head_o.valid)
      else $error("pop from empty queue");

endmodule

### rtl/mmcs_back.sv
// back end: per-channel radix-2 divide, rounding and result register
module mmcs_back import mmcs_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  head_type  head_i,
   output logic      pop_o,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output level_type rsp_out0,
   output level_type rsp_out1,
   output level_type rsp_out2
);

   localparam int unsigned NUM_W  = 2 * PIX_W;
   localparam int unsigned DSH_W  = 2 * PIX_W - 1;
   localparam int unsigned STEP_W = $clog2(PIX_W);

   typedef enum logic [1:0] {
      IDLE,
      DIVIDE,
      DRAIN
   } state_type;

   typedef struct packed {
      logic             zero;
      logic             sat;
      logic [NUM_W-1:0] num;
   } lane_setup_type;

   state_type                            state_ff, state_in;
   logic [STEP_W-1:0]                    step_ff, step_in;
   level_type                            den_ff, den_in;
   logic [DSH_W-1:0]                     dsh_ff, dsh_in;
   logic                                 color_ff, color_in;
   logic [NUM_CHAN-1:0]                  zero_ff, zero_in;
   logic [NUM_CHAN-1:0]                  sat_ff, sat_in;
   logic [NUM_CHAN-1:0][NUM_W-1:0]       rem_ff, rem_in;
   logic [NUM_CHAN-1:0][PIX_W-1:0]       quo_ff, quo_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   level_type [NUM_CHAN-1:0]             out_ff, out_in;

   lane_setup_type [NUM_CHAN-1:0]        setup;
   level_type                            den_abs;
   level_type [NUM_CHAN-1:0]             final_lvl;

   // den is |hi - lo|, shared by all lanes
   function automatic level_type range_abs(input level_type lo, input level_type hi);
      logic [PIX_W:0] d;
      d = {1'b0, hi} - {1'b0, lo};
      if (d[PIX_W]) d = -d;
      range_abs = d[PIX_W-1:0];
   endfunction

   // numerator 255*(p-lo), sign folded by the sign of the range
   function automatic lane_setup_type lane_setup(input level_type p, input level_type lo,
                                                 input level_type hi);
      logic [PIX_W:0]   d;
      logic [PIX_W:0]   diff;
      logic             pos;
      level_type        den;
      lane_setup_type   s;
      d    = {1'b0, hi} - {1'b0, lo};
      diff = {1'b0, p} - {1'b0, lo};
      if (d[PIX_W]) begin
         d    = -d;
         diff = -diff;
      end
      den    = d[PIX_W-1:0];
      pos    = !diff[PIX_W] && (diff != '0);
      s.num  = {diff[PIX_W-1:0], {PIX_W{1'b0}}} - {{PIX_W{1'b0}}, diff[PIX_W-1:0]};
      s.zero = (den == '0) || !pos;
      s.sat  = (s.num[NUM_W-1:PIX_W] >= den);
      lane_setup = s;
   endfunction

   assign den_abs = range_abs(head_i.entry.lo, head_i.entry.hi);

   always_comb begin
      for (int i = 0; i < NUM_CHAN; i++) begin
         setup[i] = lane_setup(head_i.entry.chan[i], head_i.entry.lo, head_i.entry.hi);
      end
   end

   // round half to even on the remainder, then zero or saturate
   always_comb begin
      logic [PIX_W:0] twice_r;
      logic           inc;
      logic [PIX_W:0] q9;
      for (int i = 0; i < NUM_CHAN; i++) begin
         twice_r = {rem_ff[i][PIX_W-1:0], 1'b0};
         inc     = (twice_r > {1'b0, den_ff}) ||
                   ((twice_r == {1'b0, den_ff}) && quo_ff[i][0]);
         q9      = {1'b0, quo_ff[i]} + {{PIX_W{1'b0}}, inc};
         if (zero_ff[i] || (i != 0 && !color_ff)) final_lvl[i] = LEVEL_BOTTOM;
         else if (sat_ff[i] || q9[PIX_W])         final_lvl[i] = LEVEL_TOP;
         else                                     final_lvl[i] = q9[PIX_W-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      den_in       = den_ff;
      dsh_in       = dsh_ff;
      color_in     = color_ff;
      zero_in      = zero_ff;
      sat_in       = sat_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      pop_o        = 1'b0;
      case (state_ff)
         IDLE: begin
            if (head_i.valid) begin
               pop_o    = 1'b1;
               den_in   = den_abs;
               dsh_in   = {den_abs, {(PIX_W-1){1'b0}}};
               color_in = head_i.entry.color;
               step_in  = STEP_W'(PIX_W - 1);
               for (int i = 0; i < NUM_CHAN; i++) begin
                  zero_in[i] = setup[i].zero;
                  sat_in[i]  = setup[i].sat;
                  rem_in[i]  = setup[i].num;
                  quo_in[i]  = '0;
               end
               state_in = DIVIDE;
            end
         end
         DIVIDE: begin
            for (int i = 0; i < NUM_CHAN; i++) begin
               if (rem_ff[i] >= {1'b0, dsh_ff}) begin
                  rem_in[i] = rem_ff[i] - {1'b0, dsh_ff};
                  quo_in[i] = {quo_ff[i][PIX_W-2:0], 1'b1};
               end else begin
                  quo_in[i] = {quo_ff[i][PIX_W-2:0], 1'b0};
               end
            end
            dsh_in = dsh_ff >> 1;
            if (step_ff == '0) state_in = DRAIN;
            else               step_in  = step_ff - 1'b1;
         end
         DRAIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_in       = final_lvl;
               rsp_valid_in = 1'b1;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      den_ff   <= den_in;
      dsh_ff   <= dsh_in;
      color_ff <= color_in;
      zero_ff  <= zero_in;
      sat_ff   <= sat_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      out_ff   <= out_in;
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out0  = out_ff[0];
   assign rsp_out1  = out_ff[1];
   assign rsp_out2  = out_ff[2];

   assert property (@(posedge clock) disable iff (reset) pop_o |=> (state_ff == DIVIDE))
      else $error("popped request did not start a divide");

endmodule

### rtl/min_max_contrast_stretch_top.sv
// min/max contrast stretch: top level with front, queue, back and config register
// Two-pass contrast stretch. Scan requests (req_type 0) fold the pixel into one
// running min/max (channel 0 only in grey mode, all three in color mode);
// req_frame_start on a scan restarts the range at this pixel. Apply requests
// (req_type 1) give one response per request: each used channel becomes
// round(255*(p-min)/(max-min)) with ties to even, clamped to 0..255, and 0 for a
// flat range or an unused channel. Scan requests are accepted every clock while
// the apply queue has room. An apply request snapshots the range on entry, then
// passes a load, 8 steps of the shared-divisor radix-2 divider, and a round that
// registers the response once the response register is free; only then is the
// next apply taken. The queue of QUEUE_DEPTH applies lets the scan front run ahead
// meanwhile. csr_color_mode must be written only while the block is idle; the
// block itself does not enforce this. csr_ready is always high.
module min_max_contrast_stretch_top import mmcs_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic      clock,
   input  logic      reset,
   // request channel
   input  logic      req_valid,
   output logic      req_stall,
   input  logic      req_type,
   input  logic      req_frame_start,
   input  level_type req_chan0,
   input  level_type req_chan1,
   input  level_type req_chan2,
   // response channel
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output level_type rsp_out0,
   output level_type rsp_out1,
   output level_type rsp_out2,
   // config write
   input  logic      csr_valid,
   output logic      csr_ready,
   input  logic      csr_color_mode
);

   logic     color_mode_ff, color_mode_in;
   push_type push;
   head_type head;
   logic     queue_full;
   logic     pop;

   // config register, always ready
   assign csr_ready     = 1'b1;
   assign color_mode_in = (csr_valid && csr_ready) ? csr_color_mode : color_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         color_mode_ff <= 1'b0;
      end else begin
         color_mode_ff <= color_mode_in;
      end
   end

   // front: range tracking and apply snapshot
   mmcs_front u_front (
      .clock           (clock),
      .reset           (reset),
      .color_mode      (color_mode_ff),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_frame_start (req_frame_start),
      .req_chan0       (req_chan0),
      .req_chan1       (req_chan1),
      .req_chan2       (req_chan2),
      .queue_full      (queue_full),
      .push_o          (push)
   );

   // queue of pending apply requests
   mmcs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push_i (push),
      .pop_i  (pop),
      .full_o (queue_full),
      .head_o (head)
   );

   // back: divide, round, response register
   mmcs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_i    (head),
      .pop_o     (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_out0  (rsp_out0),
      .rsp_out1  (rsp_out1),
      .rsp_out2  (rsp_out2)
   );

endmodule
